@@ rtl/ritoa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ritoa_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned STEP_BITS      = 8;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_UPPER = 7'h41;
  localparam logic [6:0] CHAR_LOWER = 7'h61;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;

  typedef struct packed {
    logic [31:0] value_bits;
    logic [4:0]  radix;
    logic        treat_unsigned;
    logic        lowercase;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_SIGN,
    ST_ISSUE,
    ST_LOAD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic load_sign;
    logic load_digit;
  } cmd_t;

  typedef struct packed {
    logic chunk_last;
    logic quot_zero;
    logic minus;
    logic out_last;
  } status_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic lower);
    logic [6:0] ch;
    if (d < 4'd10) begin
      ch = CHAR_ZERO + 7'(d);
    end else if (lower) begin
      ch = CHAR_LOWER + 7'(d - 4'd10);
    end else begin
      ch = CHAR_UPPER + 7'(d - 4'd10);
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ rtl/radix_integer_to_ascii_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Converts one integer item to ASCII text in radix 2..16 (out-of-range radix is
// clamped), one character per output item: an optional '-' (signed mode, negative
// value), then digits most significant first; last_char marks the final one. Only
// the low VALUE_BITS bits of value_bits are used. One item is converted at a time.
// Each digit comes from long division by the radix in ST_DIV (8 quotient bits per
// cycle) and is written to the digit store in ST_STORE; each character is then
// loaded into the output register (ST_SIGN for the '-', ST_LOAD for a digit) and
// held in ST_OUT while the output is stalled, and a digit-store read state
// (ST_ISSUE) comes before the first digit when there is no sign.
module radix_integer_to_ascii_core #(
  parameter int unsigned VALUE_BITS = ritoa_pkg::VALUE_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ritoa_pkg::in_item_t in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ritoa_pkg::out_item_t     out_item_o
);

  ritoa_pkg::cmd_t    cmd;
  ritoa_pkg::status_t status;

  ritoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ritoa_dp #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_item_o(out_item_o)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !out_valid_o))
    else $error("accepted item did not make the block busy");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_item_o.last_char) |=> !out_valid_o)
    else $error("output continued after last character");

  a_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while text is being emitted");
`endif

endmodule

`default_nettype wire

@@ rtl/ritoa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ritoa_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/ritoa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ritoa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire ritoa_pkg::status_t status_i,
  output ritoa_pkg::cmd_t         cmd_o
);

  ritoa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ritoa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ritoa_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ritoa_pkg::ST_DIV;
      end
      ritoa_pkg::ST_DIV: begin
        if (status_i.chunk_last) state_d = ritoa_pkg::ST_STORE;
      end
      ritoa_pkg::ST_STORE: begin
        if (!status_i.quot_zero) begin
          state_d = ritoa_pkg::ST_DIV;
        end else if (status_i.minus) begin
          state_d = ritoa_pkg::ST_SIGN;
        end else begin
          state_d = ritoa_pkg::ST_ISSUE;
        end
      end
      ritoa_pkg::ST_SIGN:  state_d = ritoa_pkg::ST_OUT;
      ritoa_pkg::ST_ISSUE: state_d = ritoa_pkg::ST_LOAD;
      ritoa_pkg::ST_LOAD:  state_d = ritoa_pkg::ST_OUT;
      ritoa_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          state_d = status_i.out_last ? ritoa_pkg::ST_IDLE : ritoa_pkg::ST_LOAD;
        end
      end
      default: state_d = ritoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ritoa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ritoa_pkg::ST_DIV:   cmd_o.div_step   = 1'b1;
      ritoa_pkg::ST_STORE: cmd_o.store      = 1'b1;
      ritoa_pkg::ST_SIGN:  cmd_o.load_sign  = 1'b1;
      ritoa_pkg::ST_ISSUE: cmd_o            = '0;
      ritoa_pkg::ST_LOAD:  cmd_o.load_digit = 1'b1;
      ritoa_pkg::ST_OUT:   out_valid_o      = 1'b1;
      default:             cmd_o            = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/ritoa_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ritoa_dp #(
  parameter int unsigned VALUE_BITS = ritoa_pkg::VALUE_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ritoa_pkg::in_item_t in_item_i,
  input  wire ritoa_pkg::cmd_t     cmd_i,
  output ritoa_pkg::status_t       status_o,
  output ritoa_pkg::out_item_t     out_item_o
);

  localparam int unsigned SB     = ritoa_pkg::STEP_BITS;
  localparam int unsigned CHUNKS = (VALUE_BITS + SB - 1) / SB;
  localparam int unsigned PADW   = CHUNKS * SB;
  localparam int unsigned SW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned AW     = $clog2(VALUE_BITS);
  localparam int unsigned CW     = $clog2(VALUE_BITS + 1);

  logic [PADW-1:0]      qr_q, qr_d;
  logic [3:0]           rem_q, rem_d;
  logic [SW-1:0]        step_q, step_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [4:0]           radix_q, radix_d;
  logic                 lower_q, lower_d;
  logic                 minus_q, minus_d;
  ritoa_pkg::out_item_t out_q, out_d;

  logic [VALUE_BITS-1:0] word;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [PADW-1:0]       div_qr;
  logic [3:0]            div_rem;
  logic [3:0]            rd_digit;

  ritoa_ram #(
    .WIDTH(4),
    .DEPTH(VALUE_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(rem_q),
    .raddr_i(idx_q),
    .rdata_o(rd_digit)
  );

  assign word = VALUE_BITS'(in_item_i.value_bits);
  assign neg  = !in_item_i.treat_unsigned && word[VALUE_BITS-1];
  assign mag  = neg ? (~word + 1'b1) : word;

  // Long division by the radix, one chunk of the word per cycle, MSB first.
  always_comb begin
    logic [4:0]    r;
    logic [SB-1:0] qbits;
    r     = {1'b0, rem_q};
    qbits = '0;
    for (int i = 0; i < SB; i++) begin
      r = {r[3:0], qr_q[PADW-1-i]};
      if (r >= radix_q) begin
        r = r - radix_q;
        qbits[SB-1-i] = 1'b1;
      end
    end
    div_rem = r[3:0];
    div_qr  = PADW'({qr_q, qbits});
  end

  always_comb begin
    qr_d    = qr_q;
    rem_d   = rem_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    radix_d = radix_q;
    lower_d = lower_q;
    minus_d = minus_q;
    out_d   = out_q;
    if (cmd_i.load) begin
      qr_d    = PADW'(mag);
      rem_d   = '0;
      step_d  = '0;
      cnt_d   = '0;
      minus_d = neg;
      lower_d = in_item_i.lowercase;
      if (in_item_i.radix < ritoa_pkg::RADIX_MIN) begin
        radix_d = ritoa_pkg::RADIX_MIN;
      end else if (in_item_i.radix > ritoa_pkg::RADIX_MAX) begin
        radix_d = ritoa_pkg::RADIX_MAX;
      end else begin
        radix_d = in_item_i.radix;
      end
    end
    if (cmd_i.div_step) begin
      qr_d   = div_qr;
      rem_d  = div_rem;
      step_d = step_q + 1'b1;
    end
    if (cmd_i.store) begin
      cnt_d  = cnt_q + 1'b1;
      idx_d  = cnt_q[AW-1:0];
      rem_d  = '0;
      step_d = '0;
    end
    if (cmd_i.load_sign) begin
      out_d.char_code = ritoa_pkg::CHAR_MINUS;
      out_d.last_char = 1'b0;
    end
    if (cmd_i.load_digit) begin
      out_d.char_code = ritoa_pkg::digit_char(rd_digit, lower_q);
      out_d.last_char = (idx_q == '0);
      if (idx_q != '0) idx_d = idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      minus_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      minus_q <= minus_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qr_q    <= qr_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    lower_q <= lower_d;
    out_q   <= out_d;
  end

  assign status_o.chunk_last = (step_q == SW'(CHUNKS - 1));
  assign status_o.quot_zero  = (qr_q == '0);
  assign status_o.minus      = minus_q;
  assign status_o.out_last   = out_q.last_char;
  assign out_item_o          = out_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_radix_integer_to_ascii_core.sv @@
`timescale 1ns / 1ps

module tb_radix_integer_to_ascii_core;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_LIMIT = 60000;
  localparam int unsigned TAIL_CYCLES = 300;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  ritoa_pkg::in_item_t  in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  ritoa_pkg::out_item_t out_item_o;

  ritoa_pkg::out_item_t pending_chars[$];
  int unsigned mismatches  = 0;
  int unsigned chars_seen  = 0;
  int unsigned cycles      = 0;
  int unsigned hold_cycles = 0;
  bit          steady      = 1'b0;

  radix_integer_to_ascii_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at char %0d: %s", chars_seen, msg);
  endtask

  // expected text of one number, sign first, digits most significant first
  function automatic void spell_number(input ritoa_pkg::in_item_t item);
    logic [31:0]          mag;
    logic [31:0]          base;
    logic [3:0]           digits [0:31];
    logic                 neg;
    int                   n;
    int                   k;
    ritoa_pkg::out_item_t ch;
    base = 32'(item.radix);
    if (item.radix < ritoa_pkg::RADIX_MIN) begin
      base = 32'(ritoa_pkg::RADIX_MIN);
    end else if (item.radix > ritoa_pkg::RADIX_MAX) begin
      base = 32'(ritoa_pkg::RADIX_MAX);
    end
    neg = !item.treat_unsigned && item.value_bits[31];
    mag = neg ? (~item.value_bits + 32'd1) : item.value_bits;
    n = 0;
    do begin
      digits[n] = 4'(mag % base);
      n++;
      mag = mag / base;
    end while (mag != 32'd0);
    if (neg) begin
      ch.char_code = ritoa_pkg::CHAR_MINUS;
      ch.last_char = 1'b0;
      pending_chars.push_back(ch);
    end
    for (k = n - 1; k >= 0; k--) begin
      if (digits[k] < 4'd10) begin
        ch.char_code = ritoa_pkg::CHAR_ZERO + 7'(digits[k]);
      end else if (item.lowercase) begin
        ch.char_code = ritoa_pkg::CHAR_LOWER + 7'(digits[k] - 4'd10);
      end else begin
        ch.char_code = ritoa_pkg::CHAR_UPPER + 7'(digits[k] - 4'd10);
      end
      ch.last_char = (k == 0);
      pending_chars.push_back(ch);
    end
  endfunction

  // valid stays high from one item to the next unless a gap is drawn
  task automatic send_number(input logic [31:0] value, input logic [4:0] radix,
                             input logic is_unsigned, input logic lower);
    ritoa_pkg::in_item_t item;
    item.value_bits     = value;
    item.radix          = radix;
    item.treat_unsigned = is_unsigned;
    item.lowercase      = lower;
    while (!steady && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    spell_number(item);
  endtask

  task automatic send_random_number();
    logic [31:0] value;
    logic [4:0]  radix;
    case ($urandom_range(4))
      0: value = $urandom;
      1: value = $urandom_range(0, 255);
      2: value = 32'h8000_0000 + $urandom_range(0, 15);
      3: value = 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: value = $urandom >> $urandom_range(0, 31);
    endcase
    radix = ($urandom_range(7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(2, 16));
    send_number(value, radix, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else if (steady) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 33);
    end
  end

  always @(posedge clk_i) begin : check_chars
    ritoa_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                  out_item_o.char_code, out_item_o.last_char));
      end else begin
        want = pending_chars.pop_front();
        if (out_item_o.char_code !== want.char_code) begin
          report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                                    out_item_o.char_code, want.char_code));
        end
        if (out_item_o.last_char !== want.last_char) begin
          report_mismatch($sformatf("last_char %0b, want %0b",
                                    out_item_o.last_char, want.last_char));
        end
      end
      chars_seen++;
    end
  end

  task automatic test_directed_edges();
    send_number(32'd0,          5'd10, 1'b0, 1'b0);
    send_number(32'd0,          5'd2,  1'b1, 1'b1);
    send_number(32'hFFFF_FFFF,  5'd10, 1'b0, 1'b0);
    send_number(32'hFFFF_FFFF,  5'd2,  1'b1, 1'b0);
    send_number(32'h8000_0000,  5'd2,  1'b0, 1'b1);
    send_number(32'h8000_0000,  5'd10, 1'b0, 1'b0);
    send_number(32'h8000_0000,  5'd16, 1'b1, 1'b1);
    send_number(32'h7FFF_FFFF,  5'd16, 1'b0, 1'b1);
    send_number(32'hDEAD_BEEF,  5'd16, 1'b1, 1'b0);
    send_number(32'hDEAD_BEEF,  5'd16, 1'b1, 1'b1);
    send_number(32'hDEAD_BEEF,  5'd16, 1'b0, 1'b1);
    send_number(32'd12345,      5'd0,  1'b0, 1'b0);
    send_number(32'd12345,      5'd1,  1'b1, 1'b0);
    send_number(32'hABCD_0123,  5'd17, 1'b1, 1'b0);
    send_number(32'hABCD_0123,  5'd31, 1'b1, 1'b1);
    send_number(32'd1295,       5'd3,  1'b0, 1'b0);
    send_number(32'hFFFF_FF85,  5'd7,  1'b0, 1'b0);
    send_number(32'd4294967295, 5'd15, 1'b1, 1'b1);
    send_number(32'd4294967295, 5'd11, 1'b1, 1'b0);
    send_number(32'd1,          5'd16, 1'b0, 1'b0);
    send_number(32'd15,         5'd16, 1'b0, 1'b0);
  endtask

  task automatic test_random_mix();
    repeat (200) send_random_number();
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (60) send_random_number();
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 500;
    repeat (40) send_random_number();
  endtask

  initial begin : run
    int unsigned guard;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_random_mix();
    test_steady_stream();
    test_backpressure();
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_chars.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      report_mismatch($sformatf("%0d expected chars never arrived", pending_chars.size()));
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ radix_integer_to_ascii_core.f @@
rtl/ritoa_pkg.sv
rtl/ritoa_ram.sv
rtl/ritoa_ctrl.sv
rtl/ritoa_dp.sv
rtl/radix_integer_to_ascii_core.sv
tb/sv/tb_radix_integer_to_ascii_core.sv
